// ----- hdl/assert_macros.svh -----
// assertion macros used by the cpu rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/sac_pkg.sv -----
// types and codes of the simple accumulator cpu
package sac_pkg;

   // item modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_EXEC  = 2'd2;

   // instruction opcodes, high nibble of the instruction byte
   localparam logic [3:0] OP_NOP = 4'h0;
   localparam logic [3:0] OP_LDA = 4'h1;
   localparam logic [3:0] OP_ADD = 4'h2;
   localparam logic [3:0] OP_SUB = 4'h3;
   localparam logic [3:0] OP_STA = 4'h4;
   localparam logic [3:0] OP_LDI = 4'h5;
   localparam logic [3:0] OP_JMP = 4'h6;
   localparam logic [3:0] OP_HLT = 4'hF;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_LOAD  = 4'b1000
   } state_type;

endpackage

// ----- hdl/simple_accumulator_cpu.sv -----
// top level of the simple accumulator cpu: sequencer, registers and program memory
//
// A tiny 8-bit accumulator computer with a MEM_BYTES-byte program and data
// memory. An item is taken when start is high and busy is low; each item
// either writes a memory byte (mode 0), reads one (mode 1) or executes one
// instruction (mode 2). Exactly one result follows every item: rsp_strobe is
// high for a single cycle and the result must be taken then, there is no way
// to hold it off. The result carries the byte read (zero unless mode 1) and
// the pc, accumulator, b register and halt flag as they stand after the item.
// A write, the unused mode 3, or an execute while halted reports straight
// from idle; a read reports from the READ state, an execute from FETCH,
// and an LDA from LOAD after FETCH, since the memory read is registered:
// an instruction needs the fetch read, and LDA a second dependent data read.
// busy is high from the accepting edge until the strobe cycle for a read or
// a fetching execute; other items never raise it. A new item may be accepted
// in the strobe cycle itself. Memory contents read as zero after reset: a
// per-byte valid bit is cleared at once by reset, so there is no clearing
// pass. Addresses from req_address and the pc are taken modulo MEM_BYTES;
// the pc itself wraps at 256. Unlisted opcodes act as NOP, and only reset
// clears the halt flag.
module simple_accumulator_cpu
   import sac_pkg::*;
#(
   parameter int MEM_BYTES = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_address,
   input  logic [7:0] req_write_data,
   output logic       rsp_strobe,
   output logic [7:0] rsp_read_data,
   output logic [7:0] rsp_program_counter,
   output logic [7:0] rsp_accumulator,
   output logic [7:0] rsp_operand_register,
   output logic       rsp_is_halted
);

`include "assert_macros.svh"

   localparam int AW = $clog2(MEM_BYTES);

   // architectural state
   state_type              state_ff, state_in;
   logic [7:0]             pc_ff, pc_in;
   logic [7:0]             acc_ff, acc_in;
   logic [7:0]             b_ff, b_in;
   logic                   halt_ff, halt_in;

   // per-byte written flags, memory reads as zero until a byte is written
   logic [MEM_BYTES-1:0]   valid_ff;
   logic                   rd_ok_ff;

   // result registers
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]             rsp_read_data_ff, rsp_read_data_in;

   // memory port
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [7:0]             mem_wdata;
   logic [AW-1:0]          mem_raddr;
   logic [7:0]             mem_rdata;
   logic [7:0]             mem_word;

   // address reduction modulo MEM_BYTES, a constant table built at elaboration
   logic [AW-1:0]          addr_mod_table [256];
   logic [AW-1:0]          addr_idx;
   logic [AW-1:0]          pc_idx;
   logic [AW-1:0]          opnd_idx;
   logic [3:0]             opcode;
   logic [3:0]             opnd;

   // a data read is in flight
   logic                   data_rd_phase;

   for (genvar g = 0; g < 256; g++) begin : g_mod
      assign addr_mod_table[g] = AW'(g % MEM_BYTES);
   end

   assign addr_idx = addr_mod_table[req_address];
   assign pc_idx   = addr_mod_table[pc_ff];

   // unwritten bytes read as zero
   assign mem_word = rd_ok_ff ? mem_rdata : 8'h00;
   assign opcode   = mem_word[7:4];
   assign opnd     = mem_word[3:0];
   // operand is below 16 and the memory holds at least 16 bytes
   assign opnd_idx = AW'(opnd);

   sac_ram #(
      .WIDTH (8),
      .DEPTH (MEM_BYTES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in         = state_ff;
      pc_in            = pc_ff;
      acc_in           = acc_ff;
      b_in             = b_ff;
      halt_in          = halt_ff;
      rsp_strobe_in    = 1'b0;
      rsp_read_data_in = 8'h00;
      mem_we           = 1'b0;
      mem_waddr        = addr_idx;
      mem_wdata        = req_write_data;
      mem_raddr        = pc_idx;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_mode)
                  MODE_WRITE: begin
                     mem_we        = 1'b1;
                     rsp_strobe_in = 1'b1;
                  end
                  MODE_READ: begin
                     mem_raddr = addr_idx;
                     state_in  = ST_READ;
                  end
                  MODE_EXEC: begin
                     // fetch at pc, or report unchanged state once halted
                     if (halt_ff) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_strobe_in    = 1'b1;
            rsp_read_data_in = mem_word;
            state_in         = ST_IDLE;
         end
         ST_FETCH: begin
            pc_in         = pc_ff + 8'd1;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            unique case (opcode)
               OP_LDA: begin
                  // second read for the data byte
                  mem_raddr     = opnd_idx;
                  rsp_strobe_in = 1'b0;
                  state_in      = ST_LOAD;
               end
               OP_ADD: begin
                  b_in   = {4'h0, opnd};
                  acc_in = acc_ff + {4'h0, opnd};
               end
               OP_SUB: begin
                  b_in   = {4'h0, opnd};
                  acc_in = acc_ff - {4'h0, opnd};
               end
               OP_STA: begin
                  mem_we    = 1'b1;
                  mem_waddr = opnd_idx;
                  mem_wdata = acc_ff;
               end
               OP_LDI: begin
                  acc_in = {4'h0, opnd};
               end
               OP_JMP: begin
                  pc_in = {4'h0, opnd};
               end
               OP_HLT: begin
                  halt_in = 1'b1;
               end
               default: begin
                  // nop and unlisted opcodes
               end
            endcase
         end
         ST_LOAD: begin
            acc_in        = mem_word;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pc_ff         <= 8'h00;
         acc_ff        <= 8'h00;
         b_ff          <= 8'h00;
         halt_ff       <= 1'b0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pc_ff         <= pc_in;
         acc_ff        <= acc_in;
         b_ff          <= b_in;
         halt_ff       <= halt_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (mem_we) begin
            valid_ff[mem_waddr] <= 1'b1;
         end
      end
      rd_ok_ff         <= valid_ff[mem_raddr];
      rsp_read_data_ff <= rsp_read_data_in;
   end

   // architectural registers hold still until the next item is accepted,
   // so they are reported directly during the strobe cycle
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_read_data        = rsp_read_data_ff;
   assign rsp_program_counter  = pc_ff;
   assign rsp_accumulator      = acc_ff;
   assign rsp_operand_register = b_ff;
   assign rsp_is_halted        = halt_ff;

   assign data_rd_phase = (state_ff == ST_READ) || (state_ff == ST_LOAD);

   // a read or a load always reports in the following cycle
   `ASSERT_NEXT(a_read_reports, clock, reset, data_rd_phase, rsp_strobe)
   // no memory write while a data read is outstanding
   `ASSERT_IMPLIES(a_no_write_in_read, clock, reset, data_rd_phase, !mem_we)
   // an item of any mode accepted on a halted machine leaves the pc alone
   `ASSERT_NEXT(a_halt_holds_pc, clock, reset, start && !busy && halt_ff, $stable(pc_ff))
   // only reset clears the halt flag
   `ASSERT_NEXT(a_halt_sticky, clock, reset, halt_ff, halt_ff)

endmodule

// ----- hdl/sac_ram.sv -----
// generic single-clock ram, one write port, one registered read port
module sac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
